/* hdl/frac_pkg.sv */
// frac_pkg: shared types, widths and command codes for the fraction
// arithmetic and reduction block. No dependencies.
`default_nettype none

package frac_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int PROD_W    = 2 * IN_WIDTH;
    // magnitude width: a sum of two products needs one bit over a product
    localparam int MAG_W     = PROD_W + 1;
    localparam int NUM_W     = 33;
    localparam int DEN_W     = 31;
    localparam int EXT_W     = (MAG_W > NUM_W) ? MAG_W : NUM_W;
    localparam int DIV_CNT_W = $clog2(MAG_W + 1);
    localparam int GCD_K_W   = $clog2(MAG_W);

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic signed [IN_WIDTH-1:0] a_num;
        logic signed [IN_WIDTH-1:0] a_den;
        logic signed [IN_WIDTH-1:0] b_num;
        logic signed [IN_WIDTH-1:0] b_den;
    } in_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    status;
    } out_t;

    // sign and magnitude of an input field
    typedef struct packed {
        logic                neg;
        logic [IN_WIDTH-1:0] mag;
    } sm_t;

    // sign and magnitude of an intermediate value
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } wide_t;

    // handshake status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic sm_t to_sm(input logic [IN_WIDTH-1:0] v);
        sm_t r;
        r.neg = v[IN_WIDTH-1];
        r.mag = v[IN_WIDTH-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/frac_mul.sv */
// frac_mul: sign-magnitude multiplier shared by all products of the block.
// Depends on frac_pkg.
`default_nettype none

module frac_mul (
    input  wire frac_pkg::sm_t   x,
    input  wire frac_pkg::sm_t   y,
    output frac_pkg::wide_t      p
);

    localparam int MW = frac_pkg::MAG_W;

    logic [frac_pkg::PROD_W-1:0] prod;

    assign prod  = x.mag * y.mag;
    assign p.neg = x.neg ^ y.neg;
    assign p.mag = MW'(prod);

endmodule

`default_nettype wire

/* hdl/frac_gcd.sv */
// frac_gcd: binary (Stein) greatest common divisor, one shift or one
// subtract per cycle. Depends on frac_pkg.
`default_nettype none

module frac_gcd (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [frac_pkg::MAG_W-1:0]    a,
    input  wire [frac_pkg::MAG_W-1:0]    b,
    output frac_pkg::unit_stat_t         stat,
    output logic [frac_pkg::MAG_W-1:0]   g
);

    localparam int MW = frac_pkg::MAG_W;
    localparam int KW = frac_pkg::GCD_K_W;

    logic [MW-1:0] a_reg, a_next;
    logic [MW-1:0] b_reg, b_next;
    logic [MW-1:0] g_reg, g_next;
    logic [KW-1:0] k_reg, k_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        g_next    = g_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            k_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (a_reg == '0)
            begin
                // b carries the odd part; restore the common power of two
                g_next    = b_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_next = a_reg - b_reg;
            end
            else
            begin
                b_next = b_reg - a_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        g_reg <= g_next;
        k_reg <= k_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign g         = g_reg;

endmodule

`default_nettype wire

/* hdl/frac_div.sv */
// frac_div: restoring divider, one quotient bit per cycle.
// Depends on frac_pkg.
`default_nettype none

module frac_div (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [frac_pkg::MAG_W-1:0]    dividend,
    input  wire [frac_pkg::MAG_W-1:0]    divisor,
    output frac_pkg::unit_stat_t         stat,
    output logic [frac_pkg::MAG_W-1:0]   quotient
);

    localparam int MW = frac_pkg::MAG_W;
    localparam int CW = frac_pkg::DIV_CNT_W;

    logic [MW-1:0] q_reg, q_next;
    logic [MW-1:0] r_reg, r_next;
    logic [MW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [MW:0]   r_sh;
    logic [MW:0]   diff;

    assign r_sh = {r_reg, q_reg[MW-1]};
    assign diff = r_sh - {1'b0, d_reg};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(MW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[MW])
            begin
                r_next = diff[MW-1:0];
                q_next = {q_reg[MW-2:0], 1'b1};
            end
            else
            begin
                r_next = r_sh[MW-1:0];
                q_next = {q_reg[MW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

`default_nettype wire

/* hdl/fraction_arith_reduce_top.sv */
// Add and subtract pass through S_MUL1, S_MUL2, S_ADD and S_MUL3; multiply and
// divide skip S_MUL2 and S_ADD. The number of binary GCD steps is data dependent.
// Error items: the input beat goes from idle straight to S_OUT, then back to idle.
// Throughput: one item at a time; the GCD loop and the shared divider set it.
// A new input beat is taken while the previous result waits in the output register.
// Reset: asynchronous active low, clears the sequencer and the output valid.
// fraction_arith_reduce_top: sequencer around frac_mul, frac_gcd and frac_div.
// Depends on frac_pkg.
`default_nettype none

module fraction_arith_reduce_top (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  wire frac_pkg::in_t  req,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output frac_pkg::out_t      rsp
);

    localparam int MW = frac_pkg::MAG_W;
    localparam int EW = frac_pkg::EXT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL1   = 4'd1;
    localparam logic [3:0] S_MUL2   = 4'd2;
    localparam logic [3:0] S_ADD    = 4'd3;
    localparam logic [3:0] S_MUL3   = 4'd4;
    localparam logic [3:0] S_GCD    = 4'd5;
    localparam logic [3:0] S_GWAIT  = 4'd6;
    localparam logic [3:0] S_DIVN   = 4'd7;
    localparam logic [3:0] S_DNWAIT = 4'd8;
    localparam logic [3:0] S_DIVD   = 4'd9;
    localparam logic [3:0] S_DDWAIT = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    frac_pkg::sm_t     an_reg, an_next;
    frac_pkg::sm_t     ad_reg, ad_next;
    frac_pkg::sm_t     bn_reg, bn_next;
    frac_pkg::sm_t     bd_reg, bd_next;
    frac_pkg::wide_t   num_reg, num_next;
    frac_pkg::wide_t   den_reg, den_next;
    frac_pkg::wide_t   t_reg, t_next;
    logic              neg_reg, neg_next;
    logic              err_reg, err_next;
    logic              rsp_valid_reg, rsp_valid_next;
    frac_pkg::out_t    rsp_reg, rsp_next;

    frac_pkg::sm_t     mul_x, mul_y;
    frac_pkg::wide_t   prod;
    frac_pkg::sm_t     in_an, in_ad, in_bn, in_bd;
    logic              in_err;

    logic              gcd_start;
    frac_pkg::unit_stat_t gcd_stat;
    logic [MW-1:0]     gcd_g;
    logic              div_start;
    logic [MW-1:0]     div_dividend;
    frac_pkg::unit_stat_t div_stat;
    logic [MW-1:0]     div_q;

    logic [EW-1:0]     num_ext, num_tc, den_ext;

    assign in_an  = frac_pkg::to_sm(req.a_num);
    assign in_ad  = frac_pkg::to_sm(req.a_den);
    assign in_bn  = frac_pkg::to_sm(req.b_num);
    assign in_bd  = frac_pkg::to_sm(req.b_den);
    assign in_err = (in_ad.mag == '0) || (in_bd.mag == '0)
                    || ((req.cmd == frac_pkg::CMD_DIV) && (in_bn.mag == '0));

    assign num_ext = EW'(num_reg.mag);
    assign num_tc  = neg_reg ? (~num_ext + 1'b1) : num_ext;
    assign den_ext = EW'(den_reg.mag);

    frac_mul u_mul (
        .x (mul_x),
        .y (mul_y),
        .p (prod)
    );

    frac_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .a     (num_reg.mag),
        .b     (den_reg.mag),
        .stat  (gcd_stat),
        .g     (gcd_g)
    );

    frac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gcd_g),
        .stat     (div_stat),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        an_next        = an_reg;
        ad_next        = ad_reg;
        bn_next        = bn_reg;
        bd_next        = bd_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        t_next         = t_reg;
        neg_next       = neg_reg;
        err_next       = err_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mul_x          = an_reg;
        mul_y          = bd_reg;
        gcd_start      = 1'b0;
        div_start      = 1'b0;
        div_dividend   = num_reg.mag;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next = req.cmd;
                    an_next  = in_an;
                    ad_next  = in_ad;
                    bn_next  = in_bn;
                    bd_next  = in_bd;
                    err_next = in_err;
                    state_next = in_err ? S_OUT : S_MUL1;
                end
            end
            S_MUL1:
            begin
                mul_x    = an_reg;
                mul_y    = (cmd_reg == frac_pkg::CMD_MUL) ? bn_reg : bd_reg;
                num_next = prod;
                state_next = ((cmd_reg == frac_pkg::CMD_ADD)
                              || (cmd_reg == frac_pkg::CMD_SUB)) ? S_MUL2 : S_MUL3;
            end
            S_MUL2:
            begin
                mul_x      = bn_reg;
                mul_y      = ad_reg;
                t_next     = prod;
                t_next.neg = prod.neg ^ (cmd_reg == frac_pkg::CMD_SUB);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (num_reg.neg == t_reg.neg)
                begin
                    num_next.mag = num_reg.mag + t_reg.mag;
                end
                else if (num_reg.mag >= t_reg.mag)
                begin
                    num_next.mag = num_reg.mag - t_reg.mag;
                end
                else
                begin
                    num_next.neg = t_reg.neg;
                    num_next.mag = t_reg.mag - num_reg.mag;
                end
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                mul_x      = ad_reg;
                mul_y      = (cmd_reg == frac_pkg::CMD_DIV) ? bn_reg : bd_reg;
                den_next   = prod;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                gcd_start  = 1'b1;
                // denominator sign moves onto the numerator
                neg_next   = (num_reg.neg != den_reg.neg) && (num_reg.mag != '0);
                state_next = S_GWAIT;
            end
            S_GWAIT:
            begin
                if (gcd_stat.done)
                begin
                    state_next = S_DIVN;
                end
            end
            S_DIVN:
            begin
                div_start    = 1'b1;
                div_dividend = num_reg.mag;
                state_next   = S_DNWAIT;
            end
            S_DNWAIT:
            begin
                if (div_stat.done)
                begin
                    num_next.mag = div_q;
                    state_next   = S_DIVD;
                end
            end
            S_DIVD:
            begin
                div_start    = 1'b1;
                div_dividend = den_reg.mag;
                state_next   = S_DDWAIT;
            end
            S_DDWAIT:
            begin
                if (div_stat.done)
                begin
                    den_next.mag = div_q;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    if (err_reg)
                    begin
                        rsp_next.res_num = '0;
                        rsp_next.res_den = '0;
                        rsp_next.status  = 1'b1;
                    end
                    else
                    begin
                        rsp_next.res_num = num_tc[frac_pkg::NUM_W-1:0];
                        rsp_next.res_den = den_ext[frac_pkg::DEN_W-1:0];
                        rsp_next.status  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        an_reg  <= an_next;
        ad_reg  <= ad_next;
        bn_reg  <= bn_next;
        bd_reg  <= bd_next;
        num_reg <= num_next;
        den_reg <= den_next;
        t_reg   <= t_next;
        neg_reg <= neg_next;
        err_reg <= err_next;
        rsp_reg <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status) |-> (rsp.res_num == '0 && rsp.res_den == '0))
        else $error("error beat carries a nonzero result");

    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.status) |-> (rsp.res_den != '0))
        else $error("ok beat with zero denominator");

    a_gcd_done: assert property (@(posedge clk) disable iff (!rst_n)
        gcd_stat.done |-> (state_reg == S_GWAIT))
        else $error("gcd finished outside its wait state");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DNWAIT || state_reg == S_DDWAIT))
        else $error("divider finished outside its wait states");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (!div_stat.busy && !gcd_stat.busy))
        else $error("divider started while a unit is busy");
`endif

endmodule

`default_nettype wire
